/* rtl/core/assert_macros.svh */
// Assertion macros shared by the timer bank RTL modules.
// Each macro expects clk_i and rst_ni to exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TDTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TDTB_ASSERT_NEVER(lbl, cond, msg) \
  `TDTB_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/core/tdtb_pkg.sv */
// Package for the timer bank: command codes, controller states and the
// control and status words between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdtb_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned TICKS_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 3'd0,
    MODE_START = 3'd1,
    MODE_STOP  = 3'd2,
    MODE_QUERY = 3'd3,
    MODE_ALLOC = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_EXEC,
    OP_TICK_LOAD,
    OP_SCAN,
    OP_FLUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/tdtb_ctrl.sv */
// Controller state machine of the timer bank: accepts commands and sequences
// the tick walk. Depends on tdtb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tdtb_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  input  wire logic [tdtb_pkg::MODE_W-1:0]    mode_i,
  input  wire tdtb_pkg::dp_status_t           status_i,
  output tdtb_pkg::ctrl_cmd_t                 cmd_o,
  output logic                                busy
);

  tdtb_pkg::state_e state_q, state_d;
  logic             is_tick;

  assign is_tick = (mode_i == tdtb_pkg::MODE_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdtb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdtb_pkg::ST_IDLE: begin
        if (start && is_tick) begin
          state_d = tdtb_pkg::ST_SCAN;
        end
      end
      tdtb_pkg::ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = tdtb_pkg::ST_FLUSH;
        end
      end
      tdtb_pkg::ST_FLUSH: begin
        state_d = tdtb_pkg::ST_IDLE;
      end
      default: begin
        state_d = tdtb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.op = tdtb_pkg::OP_IDLE;
    busy     = 1'b0;
    unique case (state_q)
      tdtb_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.op = is_tick ? tdtb_pkg::OP_TICK_LOAD : tdtb_pkg::OP_EXEC;
        end
      end
      tdtb_pkg::ST_SCAN: begin
        cmd_o.op = tdtb_pkg::OP_SCAN;
        busy     = 1'b1;
      end
      tdtb_pkg::ST_FLUSH: begin
        cmd_o.op = tdtb_pkg::OP_FLUSH;
        busy     = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `TDTB_ASSERT(a_flush_ends, (state_q == tdtb_pkg::ST_FLUSH) |=> (state_q == tdtb_pkg::ST_IDLE), "flush must return to idle")
  `TDTB_ASSERT(a_scan_entry, (state_q == tdtb_pkg::ST_SCAN && $past(state_q) == tdtb_pkg::ST_IDLE) |-> $past(start && is_tick), "walk started without a tick word")

endmodule

`default_nettype wire

/* rtl/core/tdtb_datapath.sv */
// Datapath of the timer bank: timer state, count and period memories, tick
// walk index, pending fire event and result register. Depends on tdtb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tdtb_datapath #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire tdtb_pkg::ctrl_cmd_t             cmd_i,
  output tdtb_pkg::dp_status_t                 status_o,
  input  wire logic [tdtb_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [tdtb_pkg::ID_W-1:0]       timer_id_i,
  input  wire logic [tdtb_pkg::TICKS_W-1:0]    ticks_i,
  input  wire logic                            periodic_i,
  input  wire logic                            notify_i,
  output logic                                 result_valid_o,
  output logic [tdtb_pkg::ID_W-1:0]            result_id_o,
  output logic                                 fired_o,
  output logic                                 expired_o,
  output logic                                 ok_o,
  output logic                                 last_o
);

  localparam int unsigned IDX_W   = $clog2(NUM_TIMERS);
  localparam int unsigned ALLOC_W = $clog2(NUM_TIMERS + 1);

  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] rel_mem [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] rd_cnt_q, rd_rel_q;

  logic [NUM_TIMERS-1:0]  running_q, periodic_q, notify_q, expired_q;
  logic [ALLOC_W-1:0]     alloc_q;
  logic [IDX_W-1:0]       idx_q, idx_d;

  logic                   pend_valid_q, pend_valid_d;
  logic [tdtb_pkg::ID_W-1:0] pend_id_q, pend_id_d;

  logic                   res_valid_d;
  logic [tdtb_pkg::ID_W-1:0] res_id_d;
  logic                   res_fired_d, res_exp_d, res_ok_d, res_last_d;

  logic                   is_exec, is_load, is_scan, is_flush;
  logic [IDX_W-1:0]       id_idx, rd_addr;
  logic                   id_in_bank, id_alloc, alloc_full;
  logic [COUNT_WIDTH-1:0] ticks_val, cnt_dec, cnt_wdata;
  logic [IDX_W-1:0]       cnt_waddr;
  logic                   cnt_we, rd_en;
  logic                   scan_last, scan_run, scan_hit, scan_fire;

  logic                   start_we, stop_we, alloc_inc;
  logic [tdtb_pkg::ID_W-1:0] ex_id;
  logic                   ex_ok, ex_exp;

  assign is_exec  = (cmd_i.op == tdtb_pkg::OP_EXEC);
  assign is_load  = (cmd_i.op == tdtb_pkg::OP_TICK_LOAD);
  assign is_scan  = (cmd_i.op == tdtb_pkg::OP_SCAN);
  assign is_flush = (cmd_i.op == tdtb_pkg::OP_FLUSH);

  assign id_idx     = IDX_W'(timer_id_i);
  assign id_in_bank = int'(timer_id_i) < int'(NUM_TIMERS);
  assign id_alloc   = int'(timer_id_i) < int'(alloc_q);
  assign alloc_full = int'(alloc_q) >= int'(NUM_TIMERS);
  assign ticks_val  = COUNT_WIDTH'(ticks_i);

  assign scan_last = (idx_q == IDX_W'(NUM_TIMERS - 1));
  assign scan_run  = is_scan && running_q[idx_q];
  assign cnt_dec   = rd_cnt_q - COUNT_WIDTH'(1);
  assign scan_hit  = scan_run && (cnt_dec == '0);
  assign scan_fire = scan_hit && notify_q[idx_q];

  assign status_o.scan_last = scan_last;

  always_comb begin
    ex_id     = '0;
    ex_ok     = 1'b0;
    ex_exp    = 1'b0;
    start_we  = 1'b0;
    stop_we   = 1'b0;
    alloc_inc = 1'b0;
    unique case (mode_i)
      tdtb_pkg::MODE_START: begin
        ex_id    = timer_id_i;
        ex_ok    = id_in_bank && id_alloc;
        start_we = is_exec && id_in_bank && id_alloc;
      end
      tdtb_pkg::MODE_STOP: begin
        ex_id   = timer_id_i;
        ex_ok   = id_in_bank;
        stop_we = is_exec && id_in_bank;
      end
      tdtb_pkg::MODE_QUERY: begin
        ex_id  = timer_id_i;
        ex_ok  = id_in_bank;
        ex_exp = id_in_bank && expired_q[id_idx];
      end
      tdtb_pkg::MODE_ALLOC: begin
        ex_id     = alloc_full ? '0 : tdtb_pkg::ID_W'(alloc_q);
        ex_ok     = !alloc_full;
        alloc_inc = is_exec && !alloc_full;
      end
      default: begin
        ex_id = '0;
      end
    endcase
  end

  always_comb begin
    rd_en     = is_load || is_scan;
    rd_addr   = (is_load || scan_last) ? '0 : idx_q + IDX_W'(1);
    cnt_we    = start_we || scan_run;
    cnt_waddr = start_we ? id_idx : idx_q;
    if (start_we) begin
      cnt_wdata = ticks_val;
    end else if (scan_hit) begin
      cnt_wdata = rd_rel_q;
    end else begin
      cnt_wdata = cnt_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (start_we) begin
      rel_mem[id_idx] <= ticks_val;
    end
    if (rd_en) begin
      rd_cnt_q <= cnt_mem[rd_addr];
      rd_rel_q <= rel_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= '0;
      periodic_q <= '0;
      notify_q   <= '0;
      expired_q  <= '0;
      alloc_q    <= ALLOC_W'(1);
    end else begin
      if (start_we) begin
        running_q[id_idx]  <= 1'b1;
        periodic_q[id_idx] <= periodic_i;
        notify_q[id_idx]   <= notify_i;
        expired_q[id_idx]  <= 1'b0;
      end
      if (stop_we) begin
        running_q[id_idx] <= 1'b0;
        expired_q[id_idx] <= 1'b0;
      end
      if (scan_hit) begin
        expired_q[idx_q] <= !periodic_q[idx_q];
      end
      if (alloc_inc) begin
        alloc_q <= alloc_q + ALLOC_W'(1);
      end
    end
  end

  // A fire event is held back one slot so that the final one of a tick
  // can still be marked as last when the walk ends.
  always_comb begin
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    res_valid_d  = 1'b0;
    res_id_d     = result_id_o;
    res_fired_d  = fired_o;
    res_exp_d    = expired_o;
    res_ok_d     = ok_o;
    res_last_d   = last_o;
    unique case (cmd_i.op)
      tdtb_pkg::OP_EXEC: begin
        res_valid_d = 1'b1;
        res_id_d    = ex_id;
        res_fired_d = 1'b0;
        res_exp_d   = ex_exp;
        res_ok_d    = ex_ok;
        res_last_d  = 1'b1;
      end
      tdtb_pkg::OP_TICK_LOAD: begin
        idx_d = '0;
      end
      tdtb_pkg::OP_SCAN: begin
        idx_d = idx_q + IDX_W'(1);
        if (scan_fire) begin
          pend_valid_d = 1'b1;
          pend_id_d    = tdtb_pkg::ID_W'(idx_q);
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_id_d    = pend_id_q;
            res_fired_d = 1'b1;
            res_exp_d   = 1'b0;
            res_ok_d    = 1'b1;
            res_last_d  = 1'b0;
          end
        end
      end
      tdtb_pkg::OP_FLUSH: begin
        pend_valid_d = 1'b0;
        if (pend_valid_q) begin
          res_valid_d = 1'b1;
          res_id_d    = pend_id_q;
          res_fired_d = 1'b1;
          res_exp_d   = 1'b0;
          res_ok_d    = 1'b1;
          res_last_d  = 1'b1;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q          <= '0;
      pend_valid_q   <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      idx_q          <= idx_d;
      pend_valid_q   <= pend_valid_d;
      result_valid_o <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q   <= pend_id_d;
    result_id_o <= res_id_d;
    fired_o     <= res_fired_d;
    expired_o   <= res_exp_d;
    ok_o        <= res_ok_d;
    last_o      <= res_last_d;
  end

  `TDTB_ASSERT(a_pend_in_tick, pend_valid_q |-> (is_scan || is_flush), "pending fire event outside a tick")
  `TDTB_ASSERT(a_fire_word, (result_valid_o && fired_o) |-> (ok_o && !expired_o), "fire word must carry ok and no expired flag")
  `TDTB_ASSERT_NEVER(a_alloc_range, (alloc_q == '0) || (int'(alloc_q) > int'(NUM_TIMERS)), "allocation count out of range")

endmodule

`default_nettype wire

/* rtl/core/tick_driven_timer_bank_core.sv */
// Tick walk: busy is high while the walk reads each timer in turn through the count
// memory read port and then closes the walk in the flush state; the next word is taken
// once busy has fallen, and the last fire word is out in the same cycle that busy falls.
// Other commands: one result word in the cycle after acceptance, busy stays low, one per
// cycle. Reset (asynchronous, active low) stops all timers and sets the next id to 1; count
// and period memories are not cleared and are only used after a start wrote them.
`timescale 1ns / 1ps
`default_nettype none

module tick_driven_timer_bank_core #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tdtb_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [tdtb_pkg::ID_W-1:0]       timer_id_i,
  input  wire logic [tdtb_pkg::TICKS_W-1:0]    ticks_i,
  input  wire logic                            periodic_i,
  input  wire logic                            notify_i,
  output logic                                 result_valid_o,
  output logic [tdtb_pkg::ID_W-1:0]            result_id_o,
  output logic                                 fired_o,
  output logic                                 expired_o,
  output logic                                 ok_o,
  output logic                                 last_o
);

  tdtb_pkg::ctrl_cmd_t  cmd;
  tdtb_pkg::dp_status_t status;

  tdtb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  tdtb_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (mode_i),
    .timer_id_i     (timer_id_i),
    .ticks_i        (ticks_i),
    .periodic_i     (periodic_i),
    .notify_i       (notify_i),
    .result_valid_o (result_valid_o),
    .result_id_o    (result_id_o),
    .fired_o        (fired_o),
    .expired_o      (expired_o),
    .ok_o           (ok_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
